// ===== rtl/core/hse_pkg.sv =====
// ============================================================================
// hse_pkg: shared types, constants and step functions
// Widths, register indexes and reset values for the hard sphere event time
// block, plus the one-step functions of its remainder and square-root pipes.
// ============================================================================
package hse_pkg;

    localparam int CoordW    = 32;
    localparam int OffW      = CoordW + 1;
    localparam int LenW      = 31;
    localparam int SqW       = 62;
    localparam int RadW      = 63;
    localparam int MarW      = 63;
    localparam int TolW      = 16;
    localparam int TimeW     = 33;
    localparam int RootW     = 64;
    localparam int HalfW     = 32;
    localparam int RawW      = 34;
    localparam int ThrW      = 64;
    localparam int ModSteps  = CoordW;
    localparam int RootSteps = 32;
    localparam int AddrW     = 3;

    typedef enum logic [AddrW-1:0] {
        CFG_BOX_X     = 3'd0,
        CFG_BOX_Y     = 3'd1,
        CFG_BOX_Z     = 3'd2,
        CFG_DIAMETER  = 3'd3,
        CFG_MARGIN    = 3'd4,
        CFG_TOLERANCE = 3'd5
    } cfg_idx_t;

    localparam logic [LenW-1:0] BoxReset      = 31'd655360;
    localparam logic [LenW-1:0] DiameterReset = 31'd65536;
    localparam logic [MarW-1:0] MarginReset   = '0;
    localparam logic [TolW-1:0] TolReset      = 16'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Remainder pipe item: slot 0 axial, slot 1 and 2 transverse
    typedef struct packed {
        logic [2:0][CoordW-1:0] mag;
        logic [2:0][LenW-1:0]   rem;
        logic [2:0]             neg;
        logic [2:0][LenW-1:0]   len;
    } mod_t;

    // Square-root pipe item
    typedef struct packed {
        logic [RadW-1:0]  n;
        logic [RootW-1:0] root;
        logic [LenW-1:0]  ax;
        logic [LenW-1:0]  la;
        logic             nc;
    } root_t;

    // Bring one dividend bit into each partial remainder
    function automatic mod_t mod_step(input mod_t s);
        mod_t        o;
        logic [31:0] t;
        o = s;
        for (int i = 0; i < 3; i++) begin
            t = {s.rem[i], s.mag[i][CoordW-1]};
            if (t >= {1'b0, s.len[i]}) begin
                t = t - {1'b0, s.len[i]};
            end
            o.rem[i] = t[LenW-1:0];
            o.mag[i] = {s.mag[i][CoordW-2:0], 1'b0};
        end
        return o;
    endfunction

    // One digit of the bitwise integer square root
    function automatic root_t root_step(input root_t s, input logic [RootW-1:0] b);
        root_t            o;
        logic [RootW-1:0] trial;
        o     = s;
        trial = s.root + b;
        if ({1'b0, s.n} >= trial) begin
            o.n    = s.n - trial[RadW-1:0];
            o.root = (s.root >> 1) + b;
        end else begin
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/hard_sphere_event_time_top.sv =====
// ============================================================================
// hard_sphere_event_time_top: collision distance for event chain moves
// Rotates the pair offset onto the move axis, wraps it into the periodic box,
// and returns the free path to contact or twice the box length.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  s_        in         s_valid / s_ready         mover_*, target_*, move_axis/neg
//  m_        out        m_valid / m_ready         event_time, no_contact, overlap
//  cfg_      in         cfg_valid / cfg_ready     cfg_addr, cfg_data
//
//  One pair enters per cycle unless the output stalls; a result passes one input
//  register, 32 remainder stages, four wrap/square/compare stages, 32 square
//  root stages and the output register. A stalled output freezes every stage;
//  nothing is dropped or repeated. Reset clears all valid bits and loads the
//  register defaults.
//
module hard_sphere_event_time_top
    import hse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CoordW-1:0]   s_mover_x,
    input  logic [CoordW-1:0]   s_mover_y,
    input  logic [CoordW-1:0]   s_mover_z,
    input  logic [CoordW-1:0]   s_target_x,
    input  logic [CoordW-1:0]   s_target_y,
    input  logic [CoordW-1:0]   s_target_z,
    input  logic [1:0]          s_move_axis,
    input  logic                s_move_negative,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TimeW-1:0]    m_event_time,
    output logic                m_no_contact,
    output logic                m_overlap_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [AddrW-1:0]    cfg_addr,
    input  logic [MarW-1:0]     cfg_data
);

    // Configuration registers
    logic [LenW-1:0] box_x_reg, box_y_reg, box_z_reg, diam_reg;
    logic [MarW-1:0] margin_reg;
    logic [TolW-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg  <= BoxReset;
            box_y_reg  <= BoxReset;
            box_z_reg  <= BoxReset;
            diam_reg   <= DiameterReset;
            margin_reg <= MarginReset;
            tol_reg    <= TolReset;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_BOX_X:     box_x_reg  <= cfg_data[LenW-1:0];
                CFG_BOX_Y:     box_y_reg  <= cfg_data[LenW-1:0];
                CFG_BOX_Z:     box_z_reg  <= cfg_data[LenW-1:0];
                CFG_DIAMETER:  diam_reg   <= cfg_data[LenW-1:0];
                CFG_MARGIN:    margin_reg <= cfg_data;
                CFG_TOLERANCE: tol_reg    <= cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: move when the output is free or being taken
    logic out_vld_reg;
    logic en;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // Input stage: offsets, axis rotation, magnitudes
    logic [LenW-1:0]       lx, ly, lz;
    logic signed [OffW-1:0] dx, dy, dz, ax_s, t1_s, t2_s;
    logic [LenW-1:0]       la, l1, l2;
    mod_t                  mod_next;

    assign lx = (box_x_reg == '0) ? LenW'(1) : box_x_reg;
    assign ly = (box_y_reg == '0) ? LenW'(1) : box_y_reg;
    assign lz = (box_z_reg == '0) ? LenW'(1) : box_z_reg;
    assign dx = $signed({s_target_x[CoordW-1], s_target_x})
              - $signed({s_mover_x[CoordW-1], s_mover_x});
    assign dy = $signed({s_target_y[CoordW-1], s_target_y})
              - $signed({s_mover_y[CoordW-1], s_mover_y});
    assign dz = $signed({s_target_z[CoordW-1], s_target_z})
              - $signed({s_mover_z[CoordW-1], s_mover_z});

    always_comb begin
        priority if (s_move_axis == AXIS_X) begin
            ax_s = dx; la = lx; t1_s = dy; l1 = ly; t2_s = dz; l2 = lz;
        end else if (s_move_axis == AXIS_Y) begin
            ax_s = dy; la = ly; t1_s = dz; l1 = lz; t2_s = dx; l2 = lx;
        end else begin
            ax_s = dz; la = lz; t1_s = dx; l1 = lx; t2_s = dy; l2 = ly;
        end
        if (s_move_negative) begin
            ax_s = -ax_s;
        end
        mod_next.neg[0] = ax_s[OffW-1];
        mod_next.neg[1] = t1_s[OffW-1];
        mod_next.neg[2] = t2_s[OffW-1];
        mod_next.mag[0] = ax_s[OffW-1] ? CoordW'(-ax_s) : ax_s[CoordW-1:0];
        mod_next.mag[1] = t1_s[OffW-1] ? CoordW'(-t1_s) : t1_s[CoordW-1:0];
        mod_next.mag[2] = t2_s[OffW-1] ? CoordW'(-t2_s) : t2_s[CoordW-1:0];
        mod_next.rem    = '0;
        mod_next.len[0] = la;
        mod_next.len[1] = l1;
        mod_next.len[2] = l2;
    end

    // Remainder pipe: one dividend bit per stage
    mod_t mod_reg     [0:ModSteps];
    logic mod_vld_reg [0:ModSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_vld_reg[0] <= 1'b0;
        end else if (en) begin
            mod_vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mod_reg[0] <= mod_next;
        end
    end

    for (genvar k = 0; k < ModSteps; k++) begin : g_mod
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mod_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                mod_vld_reg[k+1] <= mod_vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                mod_reg[k+1] <= mod_step(mod_reg[k]);
            end
        end
    end

    // Wrap stage: sign fix, then fold transverse offsets to half a box
    mod_t                  mf;
    logic [2:0][LenW-1:0]  pos;
    logic signed [HalfW-1:0] t1_next, t2_next;

    assign mf = mod_reg[ModSteps];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (mf.neg[i] && mf.rem[i] != '0) begin
                pos[i] = mf.len[i] - mf.rem[i];
            end else begin
                pos[i] = mf.rem[i];
            end
        end
        t1_next = ({pos[1], 1'b0} > {1'b0, mf.len[1]})
                ? $signed({1'b0, pos[1]} - {1'b0, mf.len[1]}) : $signed({1'b0, pos[1]});
        t2_next = ({pos[2], 1'b0} > {1'b0, mf.len[2]})
                ? $signed({1'b0, pos[2]} - {1'b0, mf.len[2]}) : $signed({1'b0, pos[2]});
    end

    logic                    w_vld_reg;
    logic [LenW-1:0]         w_ax_reg, w_la_reg;
    logic signed [HalfW-1:0] w_t1_reg, w_t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_vld_reg <= 1'b0;
        end else if (en) begin
            w_vld_reg <= mod_vld_reg[ModSteps];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_ax_reg <= pos[0];
            w_la_reg <= mf.len[0];
            w_t1_reg <= t1_next;
            w_t2_reg <= t2_next;
        end
    end

    // Square stage: transverse squares and squared diameter
    logic signed [2*HalfW-1:0] p1, p2;
    logic [2*LenW-1:0]         dsq;
    logic                      q_vld_reg;
    logic [SqW-1:0]            q_sq1_reg, q_sq2_reg, q_dsq_reg;
    logic [LenW-1:0]           q_ax_reg, q_la_reg;

    assign p1  = w_t1_reg * w_t1_reg;
    assign p2  = w_t2_reg * w_t2_reg;
    assign dsq = diam_reg * diam_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else if (en) begin
            q_vld_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_sq1_reg <= p1[SqW-1:0];
            q_sq2_reg <= p2[SqW-1:0];
            q_dsq_reg <= dsq;
            q_ax_reg  <= w_ax_reg;
            q_la_reg  <= w_la_reg;
        end
    end

    // Sum stage: transverse distance and contact threshold
    logic                   c_vld_reg;
    logic [SqW-1:0]         c_tsq_reg, c_dsq_reg;
    logic signed [ThrW-1:0] c_thr_reg;
    logic [LenW-1:0]        c_ax_reg, c_la_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_tsq_reg <= q_sq1_reg + q_sq2_reg;
            c_thr_reg <= $signed({2'b00, q_dsq_reg}) - $signed({1'b0, margin_reg});
            c_dsq_reg <= q_dsq_reg;
            c_ax_reg  <= q_ax_reg;
            c_la_reg  <= q_la_reg;
        end
    end

    // Decide stage: contact test and radicand
    root_t root_next;

    always_comb begin
        root_next.nc   = $signed({2'b00, c_tsq_reg}) >= c_thr_reg;
        root_next.n    = root_next.nc ? '0 : RadW'(c_dsq_reg - c_tsq_reg);
        root_next.root = '0;
        root_next.ax   = c_ax_reg;
        root_next.la   = c_la_reg;
    end

    // Square-root pipe: one result bit per stage
    root_t root_reg     [0:RootSteps];
    logic  root_vld_reg [0:RootSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_vld_reg[0] <= 1'b0;
        end else if (en) begin
            root_vld_reg[0] <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg[0] <= root_next;
        end
    end

    for (genvar k = 0; k < RootSteps; k++) begin : g_root
        localparam logic [RootW-1:0] Bit = RootW'(1) << (RadW - 1 - 2 * k);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                root_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                root_vld_reg[k+1] <= root_vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k+1] <= root_step(root_reg[k], Bit);
            end
        end
    end

    // Output stage: distance, clamp, flags
    root_t                  rf;
    logic signed [RawW-1:0] raw;
    logic [TimeW-1:0]       et_next;
    logic                   ovl_next;
    logic [TimeW-1:0]       et_reg;
    logic                   nc_reg, ovl_reg;

    assign rf  = root_reg[RootSteps];
    assign raw = $signed({3'b000, rf.ax}) - $signed({2'b00, rf.root[HalfW-1:0]});

    always_comb begin
        if (rf.nc) begin
            et_next  = {1'b0, rf.la, 1'b0};
            ovl_next = 1'b0;
        end else begin
            et_next  = (raw > 0) ? raw[TimeW-1:0] : '0;
            ovl_next = raw < -$signed({{(RawW - TolW){1'b0}}, tol_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= root_vld_reg[RootSteps];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            et_reg  <= et_next;
            nc_reg  <= rf.nc;
            ovl_reg <= ovl_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_event_time    = et_reg;
    assign m_no_contact    = nc_reg;
    assign m_overlap_error = ovl_reg;

endmodule

// ===== rtl/core/hse_checker.sv =====
// ============================================================================
// hse_checker: port-level checks for the event time block
// Watches the result channel and the flow control seen at the ports.
// ============================================================================
module hse_checker
    import hse_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [TimeW-1:0] m_event_time,
    input logic             m_no_contact,
    input logic             m_overlap_error
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_time)
            && $stable(m_no_contact) && $stable(m_overlap_error))
        else $error("stalled result changed");

    // Never flag overlap on a miss
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_no_contact && m_overlap_error))
        else $error("overlap flagged with no contact");

    // Clamp overlapping pairs to zero distance
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overlap_error |-> m_event_time == '0)
        else $error("overlap with nonzero distance");

    // Accept input whenever the output slot is free or drains
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free output");

endmodule

bind hard_sphere_event_time_top hse_checker u_hse_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_event_time    (m_event_time),
    .m_no_contact    (m_no_contact),
    .m_overlap_error (m_overlap_error)
);

// ===== test/tb_hard_sphere_event_time_top.sv =====
// ============================================================================
// Testbench for hard_sphere_event_time_top
// Streams sphere pairs through the event time block under several register
// settings and compares every result with a hand-worked value or an in-bench
// predictor of the wrapped, rotated contact distance.
// ============================================================================
module tb_hard_sphere_event_time_top;
    import hse_pkg::*;

    typedef struct {
        logic [CoordW-1:0] mx, my, mz, tx, ty, tz;
        logic [1:0]        axis;
        logic              neg;
    } pair_t;

    typedef struct {
        logic [TimeW-1:0] span;
        logic             nc;
        logic             ov;
    } hit_t;

    typedef struct {
        pair_t p;
        bit    typed;
        hit_t  h;
    } row_t;

    typedef struct {
        logic [LenW-1:0] bx, by, bz, dia;
        logic [MarW-1:0] mar;
        logic [TolW-1:0] tol;
    } regs_t;

    localparam int PhaseItems = 322;
    localparam int StallLimit = 5000;
    localparam int DrainWait  = 80;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CoordW-1:0] s_mover_x = '0, s_mover_y = '0, s_mover_z = '0;
    logic [CoordW-1:0] s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic [1:0]        s_move_axis = '0;
    logic              s_move_negative = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [TimeW-1:0]  m_event_time;
    logic              m_no_contact;
    logic              m_overlap_error;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [AddrW-1:0]  cfg_addr = '0;
    logic [MarW-1:0]   cfg_data = '0;

    regs_t cur;
    hit_t  pending_hits[$];
    int    errors = 0;
    int    pairs_sent = 0;
    int    hits_seen = 0;
    int    contacts_seen = 0;
    int    overlaps_seen = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_cnt = 0;
    int    quiet_cycles = 0;

    hard_sphere_event_time_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Integer square root, one result bit per pass
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint wrap_box(input longint v, input longint len);
        longint r;
        r = v % len;
        if (r < 0) r += len;
        return r;
    endfunction

    function automatic longint wrap_centered(input longint v, input longint len);
        longint r;
        r = wrap_box(v, len);
        if (2 * r > len) r -= len;
        return r;
    endfunction

    function automatic longint box_len(input logic [LenW-1:0] b);
        return (b == 0) ? 64'sd1 : longint'({33'b0, b});
    endfunction

    // Expected contact distance for one pair under the current registers
    function automatic hit_t contact_distance(input pair_t p);
        hit_t   h;
        longint dx, dy, dz, ax, la, t1, l1, t2, l2, tsq, dsq, thr, raw;
        dx = longint'($signed(p.tx)) - longint'($signed(p.mx));
        dy = longint'($signed(p.ty)) - longint'($signed(p.my));
        dz = longint'($signed(p.tz)) - longint'($signed(p.mz));
        if (p.axis == AXIS_X) begin
            ax = dx; la = box_len(cur.bx); t1 = dy; l1 = box_len(cur.by);
            t2 = dz; l2 = box_len(cur.bz);
        end else if (p.axis == AXIS_Y) begin
            ax = dy; la = box_len(cur.by); t1 = dz; l1 = box_len(cur.bz);
            t2 = dx; l2 = box_len(cur.bx);
        end else begin
            ax = dz; la = box_len(cur.bz); t1 = dx; l1 = box_len(cur.bx);
            t2 = dy; l2 = box_len(cur.by);
        end
        if (p.neg) ax = -ax;
        ax  = wrap_box(ax, la);
        t1  = wrap_centered(t1, l1);
        t2  = wrap_centered(t2, l2);
        tsq = t1 * t1 + t2 * t2;
        dsq = longint'({33'b0, cur.dia}) * longint'({33'b0, cur.dia});
        thr = dsq - longint'({1'b0, cur.mar});
        if (tsq >= thr) begin
            h.span = TimeW'(la * 2);
            h.nc   = 1'b1;
            h.ov   = 1'b0;
        end else begin
            raw    = ax - longint'(int_sqrt(dsq - tsq));
            h.span = (raw > 0) ? TimeW'(raw) : '0;
            h.nc   = 1'b0;
            h.ov   = (raw < -longint'({48'b0, cur.tol}));
        end
        return h;
    endfunction

    // Write one register and mirror it once the transfer completes
    task automatic write_reg(input cfg_idx_t idx, input logic [MarW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BOX_X:     cur.bx  = val[LenW-1:0];
            CFG_BOX_Y:     cur.by  = val[LenW-1:0];
            CFG_BOX_Z:     cur.bz  = val[LenW-1:0];
            CFG_DIAMETER:  cur.dia = val[LenW-1:0];
            CFG_MARGIN:    cur.mar = val;
            CFG_TOLERANCE: cur.tol = val[TolW-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic load_regs(input regs_t r);
        write_reg(CFG_BOX_X, MarW'(r.bx));
        write_reg(CFG_BOX_Y, MarW'(r.by));
        write_reg(CFG_BOX_Z, MarW'(r.bz));
        write_reg(CFG_DIAMETER, MarW'(r.dia));
        write_reg(CFG_MARGIN, r.mar);
        write_reg(CFG_TOLERANCE, MarW'(r.tol));
        cfg_valid <= 1'b0;
    endtask

    // Offer one pair, holding it until the transfer; idle cycles come first
    task automatic send_pair(input pair_t p, input bit typed, input hit_t h);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_mover_x       <= p.mx;
        s_mover_y       <= p.my;
        s_mover_z       <= p.mz;
        s_target_x      <= p.tx;
        s_target_y      <= p.ty;
        s_target_z      <= p.tz;
        s_move_axis     <= p.axis;
        s_move_negative <= p.neg;
        do @(posedge aclk); while (!s_ready);
        pending_hits.insert(pending_hits.size(), typed ? h : contact_distance(p));
        pairs_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge aclk);
        repeat (DrainWait) @(negedge aclk);
    endtask

    function automatic logic [CoordW-1:0] near_coord(input logic [CoordW-1:0] c,
                                                      input longint reach);
        if ($urandom_range(0, 9) < 7)
            return CoordW'(longint'($signed(c)) + longint'($urandom_range(0, 2 * reach))
                           - reach);
        return $urandom;
    endfunction

    // Each target coordinate mostly near the mover's, the rest anywhere
    function automatic pair_t random_pair();
        pair_t  p;
        longint reach;
        reach = 3 * longint'({33'b0, cur.dia}) + 65536;
        if (reach > 64'sd1073741824) reach = 64'sd1073741824;
        p.mx   = $urandom;
        p.my   = $urandom;
        p.mz   = $urandom;
        p.tx   = near_coord(p.mx, reach);
        p.ty   = near_coord(p.my, reach);
        p.tz   = near_coord(p.mz, reach);
        p.axis = 2'($urandom_range(0, 3));
        p.neg  = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // Result channel ready, with long hold-offs on request
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        hit_t want;
        if (m_valid && m_ready) begin
            hits_seen++;
            if (!m_no_contact) contacts_seen++;
            if (m_overlap_error) overlaps_seen++;
            if (pending_hits.size() == 0) begin
                errors++;
                $error("result with no pending pair: event_time %0d", m_event_time);
            end else begin
                want = pending_hits.pop_front();
                if (m_event_time !== want.span) begin
                    errors++;
                    $error("event_time expected %0d actual %0d", want.span, m_event_time);
                end
                if (m_no_contact !== want.nc) begin
                    errors++;
                    $error("no_contact expected %0d actual %0d", want.nc, m_no_contact);
                end
                if (m_overlap_error !== want.ov) begin
                    errors++;
                    $error("overlap_error expected %0d actual %0d", want.ov,
                           m_overlap_error);
                end
            end
        end
    end

    // Give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("tb_hard_sphere_event_time_top: done, errors");
            $finish;
        end
    end

    initial begin
        row_t  rows[$];
        row_t  r;
        regs_t set;
        pair_t p;
        hit_t  none;

        cur = '{BoxReset, BoxReset, BoxReset, DiameterReset, MarginReset, TolReset};
        none = '{'0, 1'b0, 1'b0};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pairs on the reset registers: box 10.0, diameter 1.0
        r.p = '{'0, '0, '0, '0, '0, '0, AXIS_X, 1'b0};
        r.typed = 1; r.h = '{'0, 1'b0, 1'b1};              // coincident cores
        rows = {rows, r};
        r.p.ty = 32'd131072; r.h = '{33'd1310720, 1'b1, 1'b0}; // passes beside
        rows = {rows, r};
        r.p.ty = '0; r.p.tx = 32'd196608; r.h = '{33'd131072, 1'b0, 1'b0};
        rows = {rows, r};
        r.p.neg = 1'b1; r.h = '{33'd393216, 1'b0, 1'b0};     // wraps behind
        rows = {rows, r};
        r.typed = 0;
        r.p = '{'0, '0, '0, '0, 32'd327680, '0, AXIS_X, 1'b0}; // exactly half box
        rows = {rows, r};
        r.p = '{'0, '0, '0, '0, -32'sd327680, '0, AXIS_X, 1'b0};
        rows = {rows, r};
        r.p = '{32'h8000_0000, '0, '0, 32'h7fff_ffff, '0, '0, AXIS_X, 1'b0}; // far out
        rows = {rows, r};
        r.p = '{'0, '0, '0, '0, '0, 32'd131072, 2'd3, 1'b0};  // selector three
        rows = {rows, r};
        r.p = '{'0, '0, 32'd40000, 32'd30000, 32'd200000, '0, AXIS_Y, 1'b1};
        rows = {rows, r};
        r.p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, AXIS_Z, 1'b1};
        rows = {rows, r};
        r.p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, AXIS_Y, 1'b0};
        rows = {rows, r};
        r.p = '{'0, '0, '0, 32'd32768, 32'd70000, 32'd10, AXIS_Y, 1'b0};
        rows = {rows, r};
        r.p = '{'0, '0, '0, 32'd100, 32'd65535, '0, AXIS_Z, 1'b1};  // grazing
        rows = {rows, r};
        foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].h);
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set = '{BoxReset, BoxReset, BoxReset, DiameterReset, MarginReset,
                           TolReset};
                1: set = '{31'd1, 31'd0, 31'd1, 31'd0, '0, '0};
                2: set = '{'1, '1, '1, '1, '1, '1};
                5: set = '{31'd196608, 31'd262144, 31'd327680, 31'd98304, '0, 16'd100};
                default: set = '{31'($urandom_range(65536, 1310720)),
                                  31'($urandom_range(65536, 1310720)),
                                  31'($urandom_range(65536, 1310720)),
                                  31'($urandom_range(0, 131072)),
                                  63'($urandom), 16'($urandom)};
            endcase
            load_regs(set);
            send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 57 : 0;
            recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 25 : 0;
            // Stall the results long enough for the pipe to back up
            if (ph == 0) hold_cnt = 400;
            for (int i = 0; i < PhaseItems; i++) begin
                if (ph == 2 && i == PhaseItems / 2) begin
                    s_valid <= 1'b0;
                    while (pending_hits.size() != 0) @(negedge aclk);
                    @(negedge aclk);
                end
                p = random_pair();
                send_pair(p, 1'b0, none);
            end
            drain();
        end

        $display("Sent %0d pairs over 7 register settings; %0d results,",
                 pairs_sent, hits_seen);
        $display("%0d contacts, %0d overlaps, with stalls on both channels.",
                 contacts_seen, overlaps_seen);
        if (errors == 0) begin
            $display("tb_hard_sphere_event_time_top: done, clean");
        end else begin
            $display("tb_hard_sphere_event_time_top: done, errors");
        end
        $finish;
    end

endmodule
